[src/hpvt_pkg.sv]
package hpvt_pkg;

   localparam int DATA_W     = 32;
   localparam int NUM_REGS   = 8;
   localparam int REG_W      = 64;
   localparam int IDX_W      = 4;
   localparam int SEL_W      = $clog2(NUM_REGS);
   localparam int PROD_W     = 64;
   localparam int ACC_W      = 50;
   localparam int NUM_W      = 49;
   localparam int FRAC_W     = 16;
   localparam int DIV_STAGES = 16;
   localparam int DIV_BITS   = 2;
   localparam int DIV_LAT    = DIV_STAGES + 2;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   // identity matrix
   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};

   typedef logic signed [DATA_W-1:0] q16_type;
   typedef logic signed [NUM_W-1:0]  num_type;

   typedef struct packed {
      logic [DATA_W-1:0] rem;
      logic [DATA_W-1:0] dlo;
      logic [DATA_W-1:0] quo;
      logic [DATA_W-1:0] mw;
      logic              neg;
      logic              ovf;
      logic              wz;
      logic              a_pos;
      logic              a_neg;
   } div_stage_type;

   typedef struct packed {
      logic [DATA_W-1:0] q;
      logic              sat;
   } div_res_type;

endpackage

[src/hpvt_div.sv]
module hpvt_div (
   input  logic                 clock,
   input  logic                 ce,
   input  hpvt_pkg::num_type    num,
   input  hpvt_pkg::q16_type    den,
   output hpvt_pkg::div_res_type res
);
   import hpvt_pkg::*;

   div_stage_type stage_ff [DIV_STAGES+1];
   div_stage_type stage_in [DIV_STAGES+1];
   div_res_type   res_ff, res_in;
   logic [NUM_W-2:0]  ma;
   logic [DATA_W-1:0] mw, hi;

   // two restoring steps
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type     o;
      logic [DATA_W:0]   t;
      o = s;
      for (int b = 0; b < DIV_BITS; b++) begin
         t = {o.rem, o.dlo[DATA_W-1]};
         o.dlo = {o.dlo[DATA_W-2:0], 1'b0};
         if (t >= {1'b0, o.mw}) begin
            o.rem = DATA_W'(t - {1'b0, o.mw});
            o.quo = {o.quo[DATA_W-2:0], 1'b1};
         end else begin
            o.rem = t[DATA_W-1:0];
            o.quo = {o.quo[DATA_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   always_comb begin
      ma = num[NUM_W-1] ? (NUM_W-1)'(-num) : (NUM_W-1)'(num);
      mw = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
      hi = ma[NUM_W-2:FRAC_W];
      stage_in[0].rem   = hi;
      stage_in[0].dlo   = {ma[FRAC_W-1:0], {FRAC_W{1'b0}}};
      stage_in[0].quo   = '0;
      stage_in[0].mw    = mw;
      stage_in[0].neg   = num[NUM_W-1] ^ den[DATA_W-1];
      stage_in[0].ovf   = (hi >= mw);
      stage_in[0].wz    = (den == '0);
      stage_in[0].a_pos = !num[NUM_W-1] && (num != '0);
      stage_in[0].a_neg = num[NUM_W-1];
      for (int k = 1; k <= DIV_STAGES; k++) begin
         stage_in[k] = div_step(stage_ff[k-1]);
      end
   end

   always_comb begin
      res_in.q   = '0;
      res_in.sat = 1'b0;
      if (stage_ff[DIV_STAGES].wz) begin
         if (stage_ff[DIV_STAGES].a_pos) begin
            res_in.q   = SAT_MAX;
            res_in.sat = 1'b1;
         end else if (stage_ff[DIV_STAGES].a_neg) begin
            res_in.q   = SAT_MIN;
            res_in.sat = 1'b1;
         end
      end else if (stage_ff[DIV_STAGES].ovf) begin
         res_in.q   = stage_ff[DIV_STAGES].neg ? SAT_MIN : SAT_MAX;
         res_in.sat = 1'b1;
      end else if (stage_ff[DIV_STAGES].neg) begin
         if (stage_ff[DIV_STAGES].quo > SAT_MIN) begin
            res_in.q   = SAT_MIN;
            res_in.sat = 1'b1;
         end else begin
            res_in.q = DATA_W'(-stage_ff[DIV_STAGES].quo);
         end
      end else if (stage_ff[DIV_STAGES].quo[DATA_W-1]) begin
         res_in.q   = SAT_MAX;
         res_in.sat = 1'b1;
      end else begin
         res_in.q = stage_ff[DIV_STAGES].quo;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            stage_ff[k] <= stage_in[k];
         end
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

[src/homogeneous_point_vector_transform.sv]
// Homogeneous 4x4 point transform with perspective divide (Q16.16).
// Request channel (req_): point x/y/z and vector x/y/z in tdata, has_vector
// in tuser. Response channel (rsp_): transformed point and corrected vector
// in tdata, w_zero and saturated flags in tuser.
// CSR channel (csr_): writes one 64-bit matrix register per handshake;
// index above 7 is dropped. csr_ready is always high; write only while idle.
// Throughput: one request per cycle unless the output stalls. The pipeline
// is 24 products, row sums, an 18-stage radix-4 divider for the point,
// the w-correction multiply, the vector numerators and a second 18-stage
// divider for the vector.
// Stall: all stages advance together whenever the output register is empty
// or being taken; req_tready follows that enable, so nothing is lost or
// repeated under backpressure.
// Reset: synchronous, clears all valid bits and loads the identity matrix.
module homogeneous_point_vector_transform (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // point_x, point_y, point_z, vec_x, vec_y, vec_z
   input  logic [6*hpvt_pkg::DATA_W-1:0]  req_tdata,
   // has_vector
   input  logic [0:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_x, out_y, out_z, out_vec_x, out_vec_y, out_vec_z
   output logic [6*hpvt_pkg::DATA_W-1:0]  rsp_tdata,
   // w_zero, saturated
   output logic [1:0]                     rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hpvt_pkg::IDX_W-1:0]     csr_index,
   input  logic [hpvt_pkg::REG_W-1:0]     csr_data
);
   import hpvt_pkg::*;

   typedef struct packed {
      logic              valid;
      logic              hv;
      logic              sat;
      logic              wz;
      logic [3:0][DATA_W-1:0] u;
      logic [DATA_W-1:0] h3;
   } cd_type;

   typedef struct packed {
      logic              valid;
      logic              hv;
      logic              sat;
      logic              wz;
      logic [2:0][DATA_W-1:0] po;
   } fg_type;

   logic ce;

   // matrix registers
   logic [REG_W-1:0] regs_ff [NUM_REGS];
   q16_type          m [4][4];

   // stage A: captured request
   logic    a_valid_ff, a_hv_ff;
   q16_type p_ff [3];
   q16_type v_ff [3];

   // stage B: products
   logic    b_valid_ff, b_hv_ff;
   logic signed [PROD_W-1:0] pp_ff [4][3];
   logic signed [PROD_W-1:0] vp_ff [4][3];

   // stage C: row sums
   cd_type  c_ff, c_in;
   q16_type h_ff [3];
   q16_type h_in [3];

   // delay alongside the point divider
   cd_type      d_ff [DIV_LAT];
   div_res_type pres [3];

   // stage E: w-correction products
   fg_type  e_ff, e_in;
   logic [2:0][DATA_W-1:0] e_u_ff;
   q16_type e_h3_ff;
   logic signed [PROD_W-1:0] wvp_ff [3];

   // stage F: vector numerators
   fg_type  f_ff;
   q16_type f_h3_ff;
   num_type n_ff [3];

   // delay alongside the vector divider
   fg_type      g_ff [DIV_LAT];
   div_res_type vres [3];

   // output register
   logic                    out_valid_ff, out_hv_ff;
   logic [6*DATA_W-1:0]     out_data_ff;
   logic [1:0]              out_user_ff;
   logic                    out_sat_in;
   logic [6*DATA_W-1:0]     out_data_in;

   function automatic logic [DATA_W:0] sat32(logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(SAT_MAX)) return {1'b1, SAT_MAX};
      if (v < ACC_W'(SAT_MIN)) return {1'b1, SAT_MIN};
      return {1'b0, v[DATA_W-1:0]};
   endfunction

   assign ce         = !out_valid_ff || rsp_tready;
   assign req_tready = ce;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= REG_RESET[i];
      end else if (csr_valid && (csr_index < IDX_W'(NUM_REGS))) begin
         regs_ff[csr_index[SEL_W-1:0]] <= csr_data;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            m[r][c] = regs_ff[r*2 + (c >> 1)][(c & 1)*DATA_W +: DATA_W];
         end
      end
   end

   // row sums and clipping
   always_comb begin
      logic signed [ACC_W-1:0] accp, accv;
      logic [DATA_W:0]         sp, sv;
      c_in       = '0;
      c_in.valid = b_valid_ff;
      c_in.hv    = b_hv_ff;
      for (int i = 0; i < 3; i++) h_in[i] = '0;
      for (int r = 0; r < 4; r++) begin
         accp = ACC_W'(m[r][3]);
         accv = '0;
         for (int j = 0; j < 3; j++) begin
            accp = accp + ACC_W'(pp_ff[r][j] >>> FRAC_W);
            accv = accv + ACC_W'(vp_ff[r][j] >>> FRAC_W);
         end
         sp = sat32(accp);
         sv = sat32(accv);
         c_in.sat  = c_in.sat | sp[DATA_W] | (b_hv_ff & sv[DATA_W]);
         c_in.u[r] = sv[DATA_W-1:0];
         if (r == 3) c_in.h3 = sp[DATA_W-1:0];
         else h_in[r] = sp[DATA_W-1:0];
      end
      c_in.wz = (c_in.h3 == '0);
   end

   always_comb begin
      e_in       = '0;
      e_in.valid = d_ff[DIV_LAT-1].valid;
      e_in.hv    = d_ff[DIV_LAT-1].hv;
      e_in.wz    = d_ff[DIV_LAT-1].wz;
      e_in.sat   = d_ff[DIV_LAT-1].sat | pres[0].sat | pres[1].sat | pres[2].sat;
      for (int j = 0; j < 3; j++) e_in.po[j] = pres[j].q;
   end

   always_comb begin
      out_sat_in  = g_ff[DIV_LAT-1].sat;
      out_data_in = '0;
      for (int j = 0; j < 3; j++) begin
         out_data_in[j*DATA_W +: DATA_W] = g_ff[DIV_LAT-1].po[j];
         if (g_ff[DIV_LAT-1].hv) begin
            out_data_in[(j+3)*DATA_W +: DATA_W] = vres[j].q;
            out_sat_in = out_sat_in | vres[j].sat;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_ff         <= '0;
         e_ff         <= '0;
         f_ff         <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            d_ff[k] <= '0;
            g_ff[k] <= '0;
         end
      end else if (ce) begin
         a_valid_ff   <= req_tvalid;
         b_valid_ff   <= a_valid_ff;
         c_ff         <= c_in;
         d_ff[0]      <= c_ff;
         for (int k = 1; k < DIV_LAT; k++) d_ff[k] <= d_ff[k-1];
         e_ff         <= e_in;
         f_ff         <= e_ff;
         g_ff[0]      <= f_ff;
         for (int k = 1; k < DIV_LAT; k++) g_ff[k] <= g_ff[k-1];
         out_valid_ff <= g_ff[DIV_LAT-1].valid;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (ce) begin
         a_hv_ff <= req_tuser[0];
         for (int j = 0; j < 3; j++) begin
            p_ff[j] <= req_tdata[j*DATA_W +: DATA_W];
            v_ff[j] <= req_tdata[(j+3)*DATA_W +: DATA_W];
         end
         b_hv_ff <= a_hv_ff;
         for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 3; j++) begin
               pp_ff[r][j] <= m[r][j] * p_ff[j];
               vp_ff[r][j] <= m[r][j] * v_ff[j];
            end
         end
         for (int j = 0; j < 3; j++) h_ff[j] <= h_in[j];
         e_u_ff  <= d_ff[DIV_LAT-1].u[2:0];
         e_h3_ff <= d_ff[DIV_LAT-1].h3;
         for (int j = 0; j < 3; j++) begin
            wvp_ff[j] <= $signed(d_ff[DIV_LAT-1].u[3]) * $signed(pres[j].q);
         end
         f_h3_ff <= e_h3_ff;
         for (int j = 0; j < 3; j++) begin
            n_ff[j] <= NUM_W'($signed(e_u_ff[j])) - NUM_W'(wvp_ff[j] >>> FRAC_W);
         end
         out_hv_ff   <= g_ff[DIV_LAT-1].hv;
         out_data_ff <= out_data_in;
         out_user_ff <= {out_sat_in, g_ff[DIV_LAT-1].wz};
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_div
      hpvt_div u_pdiv (
         .clock (clock),
         .ce    (ce),
         .num   (NUM_W'(h_ff[j])),
         .den   (c_ff.h3),
         .res   (pres[j])
      );
      hpvt_div u_vdiv (
         .clock (clock),
         .ce    (ce),
         .num   (n_ff[j]),
         .den   (f_h3_ff),
         .res   (vres[j])
      );
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // a nonzero point x with zero w can only come from clipping
   a_wz_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] && (rsp_tdata[DATA_W-1:0] != '0) |-> rsp_tuser[1])
      else $error("w_zero result without saturated flag");

   // no vector means zero vector fields
   a_no_vec: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_hv_ff |-> (rsp_tdata[6*DATA_W-1:3*DATA_W] == '0))
      else $error("vector fields set without a vector");

   // the divider delay line and the response valid stay in step
   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      ce && g_ff[DIV_LAT-1].valid |=> rsp_tvalid)
      else $error("result lost between divider and output");

endmodule

[tb/sv/tb_homogeneous_point_vector_transform.sv]
`timescale 1ns / 100ps

module tb_homogeneous_point_vector_transform;
   import hpvt_pkg::*;

   localparam int DRAIN_CYCLES = 80;    // longer than the pipeline

   // register indexes of the matrix map
   typedef enum int {
      R0_C01 = 0, R0_C23 = 1, R1_C01 = 2, R1_C23 = 3,
      R2_C01 = 4, R2_C23 = 5, R3_C01 = 6, R3_C23 = 7, R_UNUSED = 9
   } matrix_reg_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [6*DATA_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [6*DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0] csr_data = '0;

   homogeneous_point_vector_transform uut (.*);

   always #4 clock = ~clock;

   // Expected result: six Q16.16 words (tdata order) plus the two flags.
   typedef struct {
      logic [6*DATA_W-1:0] coords;
      logic [1:0] flags;
   } xform_result_type;

   xform_result_type pending_results[$];
   logic [REG_W-1:0] matrix_shadow[NUM_REGS];
   int mismatch_count = 0;
   bit rsp_stall_on = 1'b1;     // random backpressure enable
   bit req_gap_on = 1'b1;       // random sender gaps enable

   // ---------------- predictor ----------------
   function automatic longint mat_entry(int r, int c);
      logic [REG_W-1:0] word;
      word = matrix_shadow[r*2 + c/2];
      return (c % 2) ? longint'($signed(word[63:32])) : longint'($signed(word[31:0]));
   endfunction

   // Q16.16 product, floor
   function automatic longint qmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> 16;
   endfunction

   function automatic longint clip32(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // (a << 16) / w truncated toward zero, clipped; zero w pins a nonzero a to a rail
   function automatic longint qdivide(longint a, longint w, ref bit sat);
      logic [127:0] ma, mw, q;
      bit neg;
      if (w == 0) begin
         if (a == 0) return 0;
         sat = 1;
         return (a > 0) ? 64'sd2147483647 : -64'sd2147483648;
      end
      ma = (a < 0) ? 128'(-a) : 128'(a);
      mw = (w < 0) ? 128'(-w) : 128'(w);
      neg = (a < 0) != (w < 0);
      q = (ma << 16) / mw;
      if (neg) begin
         if (q > 128'h8000_0000) begin
            sat = 1;
            return -64'sd2147483648;
         end
         return -longint'(q);
      end
      if (q > 128'h7FFF_FFFF) begin
         sat = 1;
         return 64'sd2147483647;
      end
      return longint'(q);
   endfunction

   function automatic xform_result_type transform_point(logic [6*DATA_W-1:0] d, bit has_vec);
      xform_result_type res;
      longint pt[3], vc[3], hom[4], lin[4], pout[3], vout[3], acc, numer;
      bit sat;
      sat = 0;
      for (int j = 0; j < 3; j++) begin
         pt[j] = $signed(d[j*32 +: 32]);
         vc[j] = $signed(d[(j+3)*32 +: 32]);
         vout[j] = 0;
      end
      for (int r = 0; r < 4; r++) begin
         acc = mat_entry(r, 3);
         for (int j = 0; j < 3; j++) acc += qmul(mat_entry(r, j), pt[j]);
         hom[r] = clip32(acc, sat);
      end
      for (int j = 0; j < 3; j++) pout[j] = qdivide(hom[j], hom[3], sat);
      if (has_vec) begin
         for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += qmul(mat_entry(r, j), vc[j]);
            lin[r] = clip32(acc, sat);
         end
         for (int j = 0; j < 3; j++) begin
            numer = lin[j] - qmul(lin[3], pout[j]);
            vout[j] = qdivide(numer, hom[3], sat);
         end
      end
      for (int j = 0; j < 3; j++) begin
         res.coords[j*32 +: 32] = pout[j][31:0];
         res.coords[(j+3)*32 +: 32] = vout[j][31:0];
      end
      res.flags = {sat, hom[3] == 0};
      return res;
   endfunction

   // ---------------- drivers ----------------
   // valid stays up after the accept so requests can follow back to back;
   // a gap or wait_drained drops it
   task automatic send_request(logic [6*DATA_W-1:0] d, bit has_vec);
      int gap;
      if (req_gap_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= d;
      req_tuser <= has_vec;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(transform_point(d, has_vec));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // only called with the pipeline empty
   task automatic write_matrix_reg(matrix_reg_type idx, logic [REG_W-1:0] value);
      csr_index <= IDX_W'(idx);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_REGS) matrix_shadow[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;  // modest
         3: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [6*DATA_W-1:0] rand_request();
      logic [6*DATA_W-1:0] d;
      for (int j = 0; j < 6; j++) d[j*32 +: 32] = rand_coord();
      return d;
   endfunction

   // entry: mostly near-unity scale, sometimes rails or zero
   function automatic logic [31:0] rand_entry();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h0001_0000;
         default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   task automatic load_random_matrix();
      for (int i = 0; i < NUM_REGS; i++)
         write_matrix_reg(matrix_reg_type'(i), {rand_entry(), rand_entry()});
   endtask

   // ---------------- tests ----------------
   task automatic test_identity_directed();
      logic [6*DATA_W-1:0] d;
      // field extremes on every lane, with and without vector
      send_request({6{32'h7FFF_FFFF}}, 1'b1);
      send_request({6{32'h8000_0000}}, 1'b1);
      send_request('0, 1'b1);
      send_request({6{32'hFFFF_FFFF}}, 1'b0);
      send_request({6{32'h0001_0000}}, 1'b0);
      d = {32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000,
           32'h0002_4000, 32'hFFFF_0001, 32'h0001_0000};
      send_request(d, 1'b1);
      send_request(d, 1'b0);
   endtask

   task automatic test_perspective_directed();
      wait_drained();
      // projective row w = z: divide by depth, zero depth hits the rail
      write_matrix_reg(R3_C01, 64'h0);
      write_matrix_reg(R3_C23, 64'h0000_0000_0001_0000);
      write_matrix_reg(R_UNUSED, 64'hDEAD_BEEF_DEAD_BEEF);  // dropped
      send_request({96'h0, 32'h0, 32'h0002_0000, 32'hFFFF_0000}, 1'b0);  // w zero
      send_request('0, 1'b1);                                   // w zero, zero num
      send_request({96'h0001_0000_0001_0000_0001_0000, 32'h0000_0001,
                    32'h0005_0000, 32'h0003_0000}, 1'b1);        // tiny w, overflow
      send_request({32'h0, 32'h0001_0000, 32'h0, 32'h0002_0000,
                    32'h0004_0000, 32'hFFF8_0000}, 1'b1);
      send_request({32'h0, 32'h0001_0000, 32'h0, 32'hFFFE_0000,
                    32'h0004_0000, 32'h0008_0000}, 1'b1);        // negative w
   endtask

   task automatic test_extreme_matrix();
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) write_matrix_reg(matrix_reg_type'(i), '1);
      send_request({6{32'h7FFF_FFFF}}, 1'b1);
      send_request({6{32'h8000_0000}}, 1'b1);
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++)
         write_matrix_reg(matrix_reg_type'(i), 64'h7FFF_FFFF_8000_0000);
      send_request({6{32'h7FFF_FFFF}}, 1'b1);
      send_request({6{32'h8000_0000}}, 1'b1);
      send_request({6{32'h0000_0001}}, 1'b1);
      wait_drained();
      for (int i = 0; i < NUM_REGS; i++) write_matrix_reg(matrix_reg_type'(i), '0);
      send_request(rand_request(), 1'b1);
   endtask

   task automatic test_random_phases(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         wait_drained();
         load_random_matrix();
         for (int k = 0; k < per_phase; k++)
            send_request(rand_request(), $urandom_range(0, 3) != 0);
      end
   endtask

   task automatic test_full_rate();
      // closing stretch: no gaps, no backpressure
      wait_drained();
      load_random_matrix();
      req_gap_on = 0;
      rsp_stall_on = 0;
      for (int k = 0; k < 300; k++)
         send_request(rand_request(), 1'($urandom_range(0, 1)));
   endtask

   // ---------------- response side ----------------
   always @(negedge clock) begin
      if (reset || !rsp_stall_on) begin
         rsp_tready <= !reset;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      xform_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_tdata !== exp_res.coords || rsp_tuser !== exp_res.flags) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: exp %h/%b got %h/%b",
                           exp_res.coords, exp_res.flags, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // ---------------- sequence ----------------
   initial begin
      for (int i = 0; i < NUM_REGS; i++) matrix_shadow[i] = REG_RESET[i];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_identity_directed();
      test_perspective_directed();
      test_extreme_matrix();
      test_random_phases(3, 150);
      // sender holds off until the pipeline is fully drained
      wait_drained();
      test_random_phases(6, 180);
      test_full_rate();
      wait_drained();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

[homogeneous_point_vector_transform.f]
src/hpvt_pkg.sv
src/hpvt_div.sv
src/homogeneous_point_vector_transform.sv
tb/sv/tb_homogeneous_point_vector_transform.sv
